// ===== rtl/core/rccs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rccs_pkg;

  // Channel count and derived widths.
  localparam int NUM_CH = 8;
  localparam int CH_W = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int FRAME_CH = 8;
  localparam int SMP_W = 16;

  // Action codes on the input side.
  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Result kinds on the output side.
  localparam logic [1:0] KIND_SCALED = 2'd0;
  localparam logic [1:0] KIND_RAW = 2'd1;
  localparam logic [1:0] KIND_STARTED = 2'd2;
  localparam logic [1:0] KIND_STOPPED = 2'd3;

  // Gain derivation: gain = DIV_NUM / (2 * span), saturating at GAIN_MAX.
  // Every span below GAIN_SAT_SPAN saturates, so the divider only runs at or above it.
  localparam logic [25:0] DIV_NUM = 26'd67107840;
  localparam int DIV_STEPS = 26;
  localparam logic [15:0] GAIN_MAX = 16'hFFFF;
  localparam logic [15:0] GAIN_SAT_SPAN = 16'd512;

  // Calibration start values.
  localparam logic signed [15:0] CAL_LOW_INIT = 16'sh7FFF;
  localparam logic signed [15:0] CAL_HIGH_INIT = 16'sh8000;

  // Throttle mapping offset.
  localparam logic signed [15:0] THR_OFFSET = 16'sd16384;
  localparam logic [2:0] THR_RESET = 3'd1;

  // Per-channel defaults after reset.
  localparam logic signed [15:0] DFLT_LOW [FRAME_CH] =
    '{16'sd1131, 16'sd1084, 16'sd1128, 16'sd1082, 16'sd1081, 16'sd1081, 16'sd1081, 16'sd1081};
  localparam logic signed [15:0] DFLT_MID [FRAME_CH] =
    '{16'sd1878, 16'sd1886, 16'sd1842, 16'sd1844, 16'sd1855, 16'sd1855, 16'sd1855, 16'sd1855};
  localparam logic signed [15:0] DFLT_HIGH [FRAME_CH] =
    '{16'sd2630, 16'sd2631, 16'sd2519, 16'sd2598, 16'sd2629, 16'sd2629, 16'sd2629, 16'sd2629};
  localparam logic signed [15:0] DFLT_CLO [FRAME_CH] =
    '{16'sd1131, 16'sd1141, 16'sd1165, 16'sd1090, 16'sd1081, 16'sd1081, 16'sd1081, 16'sd1081};
  localparam logic signed [15:0] DFLT_CHI [FRAME_CH] =
    '{16'sd2625, 16'sd2631, 16'sd2519, 16'sd2598, 16'sd2629, 16'sd2629, 16'sd2629, 16'sd2629};
  localparam logic [15:0] DFLT_GAIN [FRAME_CH] =
    '{16'd44918, 16'd45038, 16'd49562, 16'd44501, 16'd43351, 16'd43351, 16'd43351, 16'd43351};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_SCALE,
    ST_DRAIN,
    ST_SPAN,
    ST_DIV,
    ST_GAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cal_step;
    logic scale_issue;
    logic span_step;
    logic div_step;
    logic gain_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ch_last;
    logic cal_mode;
    logic busy;
    logic small_span;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rc_channel_calibrate_and_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                     Contents
// input     s_axis_t{valid,ready,data,user}  raw frame or calibration command
// output    m_axis_t{valid,ready,data,user}  scaled/raw frame or acknowledgement
// config    cfg_we, cfg_wdata           throttle channel index
//
// In a scaled frame, one channel enters the shared clamp/multiply/saturate
// pipeline per cycle, and the pipeline drains before the result is loaded.
// A stop command in calibration mode derives each channel's gain, using the
// one-bit-per-cycle gain divider for spans at or above GAIN_SAT_SPAN.
// Reset is synchronous and restores the default calibration table.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only its completion waits for the output to be free.

module rc_channel_calibrate_and_scale (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // chan_0 .. chan_7, 16 bits each
  input  wire  [1:0]   s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_0 .. out_7, 16 bits each
  output logic [2:0]   m_axis_tuser,   // result_kind[1:0], calibrating
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_wdata       // throttle_channel
);
  import rccs_pkg::*;

  cmd_t cmd;
  stat_t stat;

  rccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rccs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rccs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rccs_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire  [1:0]          in_action,
  output logic                in_ready,
  input  rccs_pkg::stat_t     stat,
  output rccs_pkg::cmd_t      cmd
);
  import rccs_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_action == ACT_START) begin
            state_next = ST_FINISH;
          end else if (in_action == ACT_STOP) begin
            state_next = stat.cal_mode ? ST_SPAN : ST_FINISH;
          end else begin
            state_next = stat.cal_mode ? ST_CAL : ST_SCALE;
          end
        end
      end
      ST_CAL: begin
        cmd.cal_step = 1'b1;
        if (stat.ch_last) state_next = ST_FINISH;
      end
      ST_SCALE: begin
        cmd.scale_issue = 1'b1;
        if (stat.ch_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_FINISH;
      end
      ST_SPAN: begin
        cmd.span_step = 1'b1;
        if (!stat.small_span) begin
          state_next = ST_DIV;
        end else if (stat.ch_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_wr = 1'b1;
        state_next = stat.ch_last ? ST_FINISH : ST_SPAN;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rccs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rccs_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  rccs_pkg::cmd_t      cmd,
  output rccs_pkg::stat_t     stat,
  input  wire  [1:0]          in_action,
  input  wire  [127:0]        in_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_wdata,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [127:0]        out_data,
  output logic [2:0]          out_user
);
  import rccs_pkg::*;

  localparam logic signed [33:0] SAT_HI = 34'sd32767;
  localparam logic signed [33:0] SAT_LO = -34'sd32768;

  logic [2:0] throttle;
  logic cal_mode;
  logic [1:0] kind;
  logic [CH_W-1:0] ch;
  logic signed [15:0] samp [NUM_CH];
  logic signed [15:0] obuf [FRAME_CH];

  logic signed [15:0] raw_low [NUM_CH];
  logic signed [15:0] raw_mid [NUM_CH];
  logic signed [15:0] raw_high [NUM_CH];
  logic signed [15:0] clamp_low [NUM_CH];
  logic signed [15:0] clamp_high [NUM_CH];
  logic [15:0] gain [NUM_CH];

  // Current channel's view.
  logic signed [15:0] s_cur, lo_cur, mid_cur, hi_cur, clo_cur, chi_cur;
  assign s_cur = samp[ch];
  assign lo_cur = raw_low[ch];
  assign mid_cur = raw_mid[ch];
  assign hi_cur = raw_high[ch];
  assign clo_cur = clamp_low[ch];
  assign chi_cur = clamp_high[ch];

  // Half span of the learned range (the smaller side around mid), floored at zero.
  logic signed [16:0] span_a, span_b, span_m;
  logic [15:0] span;
  logic small_span;
  always_comb begin
    span_a = {hi_cur[15], hi_cur} - {mid_cur[15], mid_cur};
    span_b = {mid_cur[15], mid_cur} - {lo_cur[15], lo_cur};
    span_m = (span_a < span_b) ? span_a : span_b;
    span = span_m[16] ? 16'd0 : span_m[15:0];
    small_span = span < GAIN_SAT_SPAN;
  end

  // Restoring divider, one quotient bit per cycle.
  logic [16:0] rem, dvs;
  logic [25:0] quo;
  logic [4:0] dcnt;
  logic [17:0] rem_sh;
  logic [18:0] trial;
  assign rem_sh = {rem, quo[25]};
  assign trial = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (cmd.span_step && !small_span) begin
      rem <= '0;
      quo <= DIV_NUM;
      dvs <= {span, 1'b0};
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[18]) begin
        rem <= trial[16:0];
        quo <= {quo[24:0], 1'b1};
      end else begin
        rem <= rem_sh[16:0];
        quo <= {quo[24:0], 1'b0};
      end
      dcnt <= dcnt + 5'd1;
    end
  end

  // Scaling pipeline, stage one: clamp and subtract the center.
  logic signed [15:0] v_clamp;
  always_comb begin
    if (s_cur < clo_cur) v_clamp = clo_cur;
    else if (s_cur > chi_cur) v_clamp = chi_cur;
    else v_clamp = s_cur;
  end

  logic vld1, vld2;
  logic [CH_W-1:0] idx1, idx2;
  logic signed [16:0] d1;
  logic [15:0] g1;
  logic signed [33:0] p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= cmd.scale_issue;
      vld2 <= vld1;
    end
  end

  // Stage two: multiply by the gain.
  always_ff @(posedge clk) begin
    d1 <= {v_clamp[15], v_clamp} - {mid_cur[15], mid_cur};
    g1 <= gain[ch];
    idx1 <= ch;
    p2 <= $signed({1'b0, g1}) * d1;
    idx2 <= idx1;
  end

  // Stage three: floor shift, saturate and throttle mapping.
  logic signed [33:0] q;
  logic signed [15:0] q_sat, q_fin;
  logic thr_hit;
  always_comb begin
    q = p2 >>> 10;
    if (q > SAT_HI) q_sat = 16'sh7FFF;
    else if (q < SAT_LO) q_sat = 16'sh8000;
    else q_sat = q[15:0];
    thr_hit = ({1'b0, throttle} < 4'(NUM_CH)) && (throttle == 3'(idx2));
    q_fin = thr_hit ? ((q_sat >>> 1) + THR_OFFSET) : q_sat;
  end

  // Throttle register.
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle <= THR_RESET;
    end else if (cfg_we) begin
      throttle <= cfg_wdata;
    end
  end

  // Input capture, result kind, channel counter and mode flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_mode <= 1'b0;
      ch <= '0;
    end else begin
      if (cmd.load) begin
        ch <= '0;
        if (in_action == ACT_START) cal_mode <= 1'b1;
        else if (in_action == ACT_STOP) cal_mode <= 1'b0;
      end else if (cmd.cal_step || cmd.scale_issue || cmd.gain_wr ||
                   (cmd.span_step && small_span)) begin
        ch <= ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_CH; i++) samp[i] <= in_data[16*i +: 16];
      if (in_action == ACT_START) kind <= KIND_STARTED;
      else if (in_action == ACT_STOP) kind <= KIND_STOPPED;
      else kind <= cal_mode ? KIND_RAW : KIND_SCALED;
    end
  end

  // Result buffer, cleared for each item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < FRAME_CH; i++) obuf[i] <= '0;
    end else begin
      if (cmd.cal_step) obuf[ch] <= s_cur;
      if (vld2) obuf[idx2] <= q_fin;
    end
  end

  // Calibration table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        raw_low[i] <= DFLT_LOW[i];
        raw_mid[i] <= DFLT_MID[i];
        raw_high[i] <= DFLT_HIGH[i];
        clamp_low[i] <= DFLT_CLO[i];
        clamp_high[i] <= DFLT_CHI[i];
        gain[i] <= DFLT_GAIN[i];
      end
    end else begin
      if (cmd.load && in_action == ACT_START) begin
        for (int i = 0; i < NUM_CH; i++) begin
          raw_low[i] <= CAL_LOW_INIT;
          raw_high[i] <= CAL_HIGH_INIT;
          raw_mid[i] <= '0;
        end
      end
      if (cmd.cal_step) begin
        if (s_cur < lo_cur) raw_low[ch] <= s_cur;
        else if (s_cur > hi_cur) raw_high[ch] <= s_cur;
        else if (mid_cur == 16'sd0) raw_mid[ch] <= s_cur;
      end
      if (cmd.span_step) begin
        clamp_low[ch] <= mid_cur - $signed(span);
        clamp_high[ch] <= mid_cur + $signed(span);
        if (small_span) gain[ch] <= GAIN_MAX;
      end
      if (cmd.gain_wr) gain[ch] <= quo[15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < FRAME_CH; i++) out_data[16*i +: 16] <= obuf[i];
      out_user <= {cal_mode, kind};
    end
  end

  assign stat.ch_last = (ch == CH_W'(NUM_CH - 1));
  assign stat.cal_mode = cal_mode;
  assign stat.busy = vld1 | vld2;
  assign stat.small_span = small_span;
  assign stat.div_last = (dcnt == 5'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire
